// File: rtl/almmt_pkg.sv
// Package for the array list min/max table: request and response types,
// request kind codes, status codes and sequencer states. No dependencies.
package almmt_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned PosW   = 7;
  localparam int unsigned CountW = 8;

  // Request kinds.
  localparam logic [1:0] REQ_APPEND    = 2'd0;
  localparam logic [1:0] REQ_OVERWRITE = 2'd1;
  localparam logic [1:0] REQ_DELETE    = 2'd2;
  localparam logic [1:0] REQ_READ      = 2'd3;

  // Status codes.
  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_FULL    = 2'd1;
  localparam logic [1:0] STAT_BAD_POS = 2'd2;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [PosW-1:0]          position;
    logic signed [ValueW-1:0] new_value;
  } list_req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [ValueW-1:0] read_value;
    logic [CountW-1:0]        item_count;
    logic                     is_empty;
    logic signed [ValueW-1:0] largest;
    logic signed [ValueW-1:0] smallest;
  } list_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SH_RD,
    ST_SH_WR,
    ST_RD,
    ST_RD_CAP,
    ST_SCAN,
    ST_DONE
  } list_state_t;

endpackage

// File: rtl/almmt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module almmt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/array_list_min_max_table_core.sv
// Array list with min/max table: one request at a time through a sequencer
// around one RAM. Every request ends with a scan of all entries for the
// largest and smallest values, and a delete first moves the later entries
// down one place. The next request can be taken in the same cycle as the
// response shows. Reset clears the count and control, not the RAM.
module array_list_min_max_table_core #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  almmt_pkg::list_req_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output almmt_pkg::list_rsp_t out_data
);

  import almmt_pkg::*;

  localparam int unsigned AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > PosW) ? CW : PosW;

  list_state_t state_r, state_nxt;
  list_req_t   req_r, req_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [ValueW-1:0] rd_r, rd_nxt;
  logic [ValueW-1:0] hi_r, hi_nxt;
  logic [ValueW-1:0] lo_r, lo_nxt;
  logic              first_r, first_nxt;
  logic              rv_r, rv_nxt;
  logic              out_valid_r, out_valid_nxt;
  list_rsp_t         out_data_r, out_data_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [ValueW-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [ValueW-1:0] ram_rdata;

  logic [CW-1:0] idx_inc;
  logic          is_full;
  logic          in_bad_pos;
  logic          shift_more;
  logic          scan_more;
  logic          out_free;

  assign idx_inc    = CW'(idx_r + 1'b1);
  assign is_full    = (count_r == CW'(CAPACITY));
  assign in_bad_pos = (CMPW'(in_data.position) >= CMPW'(count_r));
  assign shift_more = (idx_inc < count_r);
  assign scan_more  = (idx_r < count_r);
  assign out_free   = !out_valid_r || out_ready;

  almmt_ram #(
    .WIDTH(ValueW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.req_type == REQ_APPEND) begin
            state_nxt = is_full ? ST_SCAN : ST_WRITE;
          end else if (in_bad_pos) begin
            state_nxt = ST_SCAN;
          end else begin
            unique case (in_data.req_type)
              REQ_OVERWRITE: state_nxt = ST_WRITE;
              REQ_DELETE:    state_nxt = ST_SH_RD;
              default:       state_nxt = ST_RD;
            endcase
          end
        end
      end
      ST_WRITE:  state_nxt = ST_SCAN;
      ST_SH_RD:  state_nxt = shift_more ? ST_SH_WR : ST_SCAN;
      ST_SH_WR:  state_nxt = ST_SH_RD;
      ST_RD:     state_nxt = ST_RD_CAP;
      ST_RD_CAP: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (!scan_more && !rv_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // RAM port control and handshake outputs.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r[AW-1:0];
    ram_wdata = req_r.new_value;
    ram_raddr = idx_r[AW-1:0];
    unique case (state_r)
      ST_WRITE: ram_we = 1'b1;
      ST_SH_RD: ram_raddr = idx_inc[AW-1:0];
      ST_SH_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      default: ;
    endcase
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Datapath.
  always_comb begin
    req_nxt       = req_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    status_nxt    = status_r;
    rd_nxt        = rd_r;
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    first_nxt     = first_r;
    rv_nxt        = rv_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt    = in_data;
          status_nxt = STAT_DONE;
          rd_nxt     = '0;
          if (in_data.req_type == REQ_APPEND) begin
            if (is_full) begin
              status_nxt = STAT_FULL;
            end
            idx_nxt = count_r;
          end else if (in_bad_pos) begin
            status_nxt = STAT_BAD_POS;
          end else begin
            idx_nxt = CW'(in_data.position);
          end
        end
      end
      ST_WRITE: begin
        if (req_r.req_type == REQ_APPEND) begin
          count_nxt = CW'(count_r + 1'b1);
        end
      end
      ST_SH_RD: begin
        if (!shift_more) begin
          count_nxt = CW'(count_r - 1'b1);
        end
      end
      ST_SH_WR:  idx_nxt = idx_inc;
      ST_RD_CAP: rd_nxt = ram_rdata;
      ST_SCAN: begin
        rv_nxt = scan_more;
        if (scan_more) begin
          idx_nxt = idx_inc;
        end
        if (rv_r) begin
          first_nxt = 1'b0;
          if (first_r || ($signed(ram_rdata) > $signed(hi_r))) begin
            hi_nxt = ram_rdata;
          end
          if (first_r || ($signed(ram_rdata) < $signed(lo_r))) begin
            lo_nxt = ram_rdata;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.status     = status_r;
          out_data_nxt.read_value = rd_r;
          out_data_nxt.item_count = CountW'(count_r);
          out_data_nxt.is_empty   = (count_r == '0);
          out_data_nxt.largest    = hi_r;
          out_data_nxt.smallest   = lo_r;
        end
      end
      default: ;
    endcase

    // Every path into the scan starts it from entry zero with cleared extremes.
    if (state_nxt == ST_SCAN && state_r != ST_SCAN) begin
      idx_nxt   = '0;
      hi_nxt    = '0;
      lo_nxt    = '0;
      first_nxt = 1'b1;
      rv_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      first_r     <= 1'b1;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      first_r     <= first_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    status_r   <= status_nxt;
    rd_r       <= rd_nxt;
    hi_r       <= hi_nxt;
    lo_r       <= lo_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// File: rtl/almmt_checker.sv
// Port-level checks for the array list core, bound to the core module.
// Depends on almmt_pkg and array_list_min_max_table_core.
module almmt_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input almmt_pkg::list_req_t in_data,
  input logic                 out_valid,
  input logic                 out_ready,
  input almmt_pkg::list_rsp_t out_data
);

  import almmt_pkg::*;

  // A waiting response holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("response changed while stalled");

  // The block works on one request at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  a_empty_zeros: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_empty |->
      out_data.largest == '0 && out_data.smallest == '0 && out_data.read_value == '0)
    else $error("empty list reported nonzero values");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_empty |-> $signed(out_data.largest) >= $signed(out_data.smallest))
    else $error("largest below smallest");

  a_rd_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != STAT_DONE |-> out_data.read_value == '0)
    else $error("read value on failed request");

endmodule

bind array_list_min_max_table_core almmt_checker u_almmt_checker (.*);
